// File: design/assert_macros.svh
// Assertion macros shared by the block's modules.
// Depends on nothing; each user must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/abf_pkg.sv
// Types and constants for the ALU with barrel shifter and flags.
// Depends on nothing.
package abf_pkg;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] rn_value;
        logic [31:0] rm_value;
        logic [31:0] rs_value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  dest_index;
        logic        write_enable;
        logic [31:0] result_value;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        bad_opcode;
    } t_out_word;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
    } t_nzc;

    typedef struct packed {
        logic [31:0] operand;
        logic        carry;
    } t_shift_res;

endpackage

// File: design/abf_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on abf_pkg.
interface abf_in_if;
    logic                 valid;
    logic                 ready;
    abf_pkg::t_in_word    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface abf_out_if;
    logic                 valid;
    logic                 ready;
    abf_pkg::t_out_word   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/abf_shifter.sv
// Operand 2 barrel shifter: rotated immediate or shifted Rm, with shifter carry.
// Depends on abf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abf_shifter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [31:0]             i_instr_word,
    input  logic [31:0]             i_rm_value,
    input  logic [31:0]             i_rs_value,
    input  logic                    i_cur_c,
    output abf_pkg::t_shift_res     o_shift
);

    logic [7:0]  w_amt;
    logic [4:0]  w_amt_lo;
    logic        w_amt_big;
    logic        w_amt_32;
    logic        w_sign;
    logic [63:0] w_lsl;
    logic [63:0] w_lsr;
    logic [63:0] w_asr;
    logic [63:0] w_ror;
    logic [63:0] w_imm;
    logic [4:0]  w_imm_rot;

    assign w_amt     = i_instr_word[4] ? i_rs_value[7:0] : {3'b000, i_instr_word[11:7]};
    assign w_amt_lo  = w_amt[4:0];
    assign w_amt_big = |w_amt[7:5];
    assign w_amt_32  = (w_amt == 8'd32);
    assign w_sign    = i_rm_value[31];

    assign w_lsl = {32'b0, i_rm_value} << w_amt_lo;
    assign w_lsr = {i_rm_value, 32'b0} >> w_amt_lo;
    assign w_asr = $unsigned($signed({i_rm_value, 32'b0}) >>> w_amt_lo);
    assign w_ror = {i_rm_value, i_rm_value} >> w_amt_lo;

    assign w_imm_rot = {i_instr_word[11:8], 1'b0};
    assign w_imm     = {24'b0, i_instr_word[7:0], 24'b0, i_instr_word[7:0]} >> w_imm_rot;

    always_comb begin
        o_shift = '0;
        if (i_instr_word[25]) begin
            o_shift.operand = w_imm[31:0];
            o_shift.carry   = i_cur_c;
        end else if (w_amt == 8'd0) begin
            o_shift.operand = i_rm_value;
            o_shift.carry   = 1'b0;
        end else begin
            unique case (i_instr_word[6:5])
                abf_pkg::SH_LSL: begin
                    if (w_amt_big) begin
                        o_shift.operand = '0;
                        o_shift.carry   = w_amt_32 ? i_rm_value[0] : 1'b0;
                    end else begin
                        o_shift.operand = w_lsl[31:0];
                        o_shift.carry   = w_lsl[32];
                    end
                end
                abf_pkg::SH_LSR: begin
                    if (w_amt_big) begin
                        o_shift.operand = '0;
                        o_shift.carry   = w_amt_32 ? w_sign : 1'b0;
                    end else begin
                        o_shift.operand = w_lsr[63:32];
                        o_shift.carry   = w_lsr[31];
                    end
                end
                abf_pkg::SH_ASR: begin
                    if (w_amt_big) begin
                        o_shift.operand = {32{w_sign}};
                        o_shift.carry   = w_sign;
                    end else begin
                        o_shift.operand = w_asr[63:32];
                        o_shift.carry   = w_asr[31];
                    end
                end
                abf_pkg::SH_ROR: begin
                    // The last bit rotated out always lands in bit 31.
                    o_shift.operand = w_ror[31:0];
                    o_shift.carry   = w_ror[31];
                end
                default: begin
                    o_shift.operand = i_rm_value;
                    o_shift.carry   = 1'b0;
                end
            endcase
        end
    end

    `ABF_ASSERT_NOW(a_imm_keeps_c, i_instr_word[25], o_shift.carry == i_cur_c, "imm carry lost")

endmodule

// File: design/alu_barrel_shift_flags.sv
// Top level of the data-processing ALU with barrel shifter and N, Z, C flags.
// Depends on abf_pkg, abf_if, abf_shifter and assert_macros.svh.
// The block takes one instruction word per clock while the result side takes its words, and
// returns one result word for each, in order. A word is held in the input register, then the
// shifter, the adder and the flag logic run in one pass into the result register, where the
// result word is offered until it is taken; the stored flags are updated at the same edge
// that loads the result register, so a following word sees them with no bubble. Either
// register holds its word while the next stage stalls.
`include "assert_macros.svh"

module alu_barrel_shift_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abf_in_if.sink      i_in,
    abf_out_if.source   o_out
);

    logic                 r_in_valid;
    abf_pkg::t_in_word    r_in;
    logic                 r_out_valid;
    abf_pkg::t_out_word   r_out;
    abf_pkg::t_nzc        r_flags;
    abf_pkg::t_nzc        n_flags;
    abf_pkg::t_out_word   n_out;

    logic                 w_advance;
    logic                 w_fire;
    logic [3:0]           w_opcode;
    logic                 w_s;
    abf_pkg::t_shift_res  w_shift;
    logic [31:0]          w_add_a;
    logic [31:0]          w_add_b;
    logic                 w_add_cin;
    logic [32:0]          w_sum;
    logic [31:0]          w_res;
    logic                 w_c;
    logic                 w_we;
    logic                 w_bad;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    assign w_opcode = r_in.instr_word[24:21];
    assign w_s      = r_in.instr_word[20];

    abf_shifter u_shifter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr_word (r_in.instr_word),
        .i_rm_value   (r_in.rm_value),
        .i_rs_value   (r_in.rs_value),
        .i_cur_c      (r_flags.c),
        .o_shift      (w_shift)
    );

    always_comb begin
        w_add_a   = r_in.rn_value;
        w_add_b   = w_shift.operand;
        w_add_cin = 1'b0;
        case (w_opcode) inside
            abf_pkg::OP_SUB, abf_pkg::OP_CMP: begin
                w_add_b   = ~w_shift.operand;
                w_add_cin = 1'b1;
            end
            abf_pkg::OP_RSB: begin
                w_add_a   = w_shift.operand;
                w_add_b   = ~r_in.rn_value;
                w_add_cin = 1'b1;
            end
            default: begin
                w_add_cin = 1'b0;
            end
        endcase
    end

    assign w_sum = {1'b0, w_add_a} + {1'b0, w_add_b} + {32'b0, w_add_cin};

    always_comb begin
        w_res = '0;
        w_c   = w_shift.carry;
        w_we  = 1'b0;
        w_bad = 1'b0;
        unique case (w_opcode) inside
            abf_pkg::OP_AND, abf_pkg::OP_TST: begin
                w_res = r_in.rn_value & w_shift.operand;
                w_we  = (w_opcode == abf_pkg::OP_AND);
            end
            abf_pkg::OP_EOR, abf_pkg::OP_TEQ: begin
                w_res = r_in.rn_value ^ w_shift.operand;
                w_we  = (w_opcode == abf_pkg::OP_EOR);
            end
            abf_pkg::OP_SUB, abf_pkg::OP_RSB, abf_pkg::OP_ADD, abf_pkg::OP_CMP: begin
                w_res = w_sum[31:0];
                w_c   = w_sum[32];
                w_we  = (w_opcode != abf_pkg::OP_CMP);
            end
            abf_pkg::OP_ORR: begin
                w_res = r_in.rn_value | w_shift.operand;
                w_we  = 1'b1;
            end
            abf_pkg::OP_MOV: begin
                w_res = w_shift.operand;
                w_we  = 1'b1;
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_flags = r_flags;
        if (w_s && !w_bad) begin
            n_flags.n = w_res[31];
            n_flags.z = (w_res == 32'd0);
            n_flags.c = w_c;
        end
        n_out.dest_index   = r_in.instr_word[15:12];
        n_out.write_enable = w_we;
        n_out.result_value = w_res;
        n_out.flag_n       = n_flags.n;
        n_out.flag_z       = n_flags.z;
        n_out.flag_c       = n_flags.c;
        n_out.bad_opcode   = w_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `ABF_ASSERT_NEXT(a_flags_idle, !w_fire, $stable(r_flags), "flags moved with no word")
    `ABF_ASSERT_NEXT(a_flags_bad, w_fire && w_bad, $stable(r_flags), "bad opcode changed flags")
    `ABF_ASSERT_NOW(a_bad_quiet, r_out_valid && r_out.bad_opcode, !r_out.write_enable && r_out.result_value == 32'd0, "bad opcode wrote")
    `ABF_ASSERT_NEXT(a_out_flags, w_fire, r_out.flag_c == r_flags.c && r_out.flag_z == r_flags.z, "output flags differ from stored flags")

endmodule
